### hdl/tcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcc_pkg;

  // grid geometry
  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int SCROLL_ROWS = 24;
  localparam int SCROLL_H    = (SCROLL_ROWS < ROWS) ? SCROLL_ROWS : ROWS;
  localparam int CELLS       = ROWS * COLUMNS;

  // field widths
  localparam int OP_W   = 3;
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int POS_W  = 11;
  localparam int CELL_W = 2 * CHAR_W;

  // widened row/column for cursor arithmetic and range checks
  localparam int ROWX_W = 7;
  localparam int COLX_W = 8;
  localparam int PROD_W = ROW_W + COL_W + 1;
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [ROWX_W-1:0] ROWS_X     = ROWX_W'(ROWS);
  localparam logic [ROWX_W-1:0] SCROLL_H_X = ROWX_W'(SCROLL_H);
  localparam logic [COLX_W-1:0] COLS_X     = COLX_W'(COLUMNS);
  localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
  localparam logic [ROW_W-1:0]  SCROLL_TOP = ROW_W'(SCROLL_H - 1);
  localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);

  localparam logic [ADDR_W-1:0] A_COLS        = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] A_LAST_CELL   = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] A_MOVED       = ADDR_W'((SCROLL_H - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] A_LAST_SCROLL = ADDR_W'(SCROLL_H * COLUMNS - 1);

  // operation codes
  localparam logic [OP_W-1:0] OP_PUT    = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
  localparam logic [OP_W-1:0] OP_CURSOR = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  // character codes
  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [COLX_W-1:0] TAB_STEP = COLX_W'(4);
  localparam logic [COLX_W-1:0] TAB_MASK = ~COLX_W'(3);

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [CHAR_W-1:0] char_code;
    logic [CHAR_W-1:0] color;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } tcc_in_t;

  typedef struct packed {
    logic [ROW_W-1:0]  caret_row;
    logic [COL_W-1:0]  caret_col;
    logic [POS_W-1:0]  cursor_position;
    logic [CHAR_W-1:0] cell_char;
    logic [CHAR_W-1:0] cell_color;
    logic              scrolled;
  } tcc_out_t;

  // result of one item as the sequencer finishes it
  typedef struct packed {
    logic [ROW_W-1:0]  caret_row;
    logic [COL_W-1:0]  caret_col;
    logic [CHAR_W-1:0] cell_char;
    logic [CHAR_W-1:0] cell_color;
    logic              scrolled;
  } tcc_res_t;

  // cell store access for one cycle
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } tcc_ram_req_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_CLEAR,
    ST_SCROLL,
    ST_BLANK
  } tcc_state_t;

  function automatic logic [PROD_W-1:0] lin_pos(input logic [ROW_W-1:0] r,
                                                input logic [COL_W-1:0] c);
    lin_pos = PROD_W'(r) * PROD_W'(COLUMNS) + PROD_W'(c);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    logic [PROD_W-1:0] p;
    p = lin_pos(r, c);
    cell_addr = p[ADDR_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] cursor_pos(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    logic [PROD_W-1:0] p;
    p = lin_pos(r, c);
    cursor_pos = p[POS_W-1:0];
  endfunction

  function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0] ch,
                                                  input logic [CHAR_W-1:0] color);
    make_cell = {color, ch};
  endfunction

endpackage

`default_nettype wire

### hdl/tcc_cell_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tcc_cell_ram
  import tcc_pkg::*;
(
  input  wire logic         clk,
  input  wire tcc_ram_req_t req,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/tcc_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module tcc_seq
  import tcc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire tcc_in_t           in_item,
  output logic                   busy,
  output tcc_ram_req_t           ram_req,
  input  wire logic [CELL_W-1:0] ram_rdata,
  output logic                   done,
  output tcc_res_t               res
);

  tcc_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;
  logic [ADDR_W-1:0] waddr_r, waddr_nxt;
  logic [CHAR_W-1:0] color_r, color_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_INIT;
      cnt_r     <= '0;
      pend_r    <= 1'b0;
      waddr_r   <= '0;
      color_r   <= '0;
      cur_row_r <= '0;
      cur_col_r <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      pend_r    <= pend_nxt;
      waddr_r   <= waddr_nxt;
      color_r   <= color_nxt;
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    logic [ROWX_W-1:0] r_x;
    logic [COLX_W-1:0] c_x;
    logic [ROW_W-1:0]  bs_row;
    logic [COL_W-1:0]  bs_col;

    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    pend_nxt    = 1'b0;
    waddr_nxt   = waddr_r;
    color_nxt   = color_r;
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    ram_req     = '0;
    done        = 1'b0;
    res         = '0;
    r_x         = {2'b00, cur_row_r};
    c_x         = {1'b0, cur_col_r};
    bs_row      = cur_row_r;
    bs_col      = cur_col_r;

    unique case (state_r)
      ST_INIT, ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cnt_r;
        ram_req.wdata = make_cell(CH_SPACE, color_r);
        if (cnt_r == A_LAST_CELL) begin
          state_nxt = ST_IDLE;
          done      = (state_r == ST_CLEAR);
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (start) begin
          color_nxt = in_item.color;
          unique case (in_item.operation)
            OP_PUT: begin
              if (in_item.char_code == CH_BS) begin
                if (cur_col_r != '0) begin
                  bs_col = cur_col_r - 1'b1;
                end else if (cur_row_r != '0) begin
                  bs_row = cur_row_r - 1'b1;
                  bs_col = COL_LAST;
                end
                cur_row_nxt   = bs_row;
                cur_col_nxt   = bs_col;
                ram_req.we    = 1'b1;
                ram_req.waddr = cell_addr(bs_row, bs_col);
                ram_req.wdata = make_cell(CH_SPACE, in_item.color);
                done          = 1'b1;
              end else begin
                if (in_item.char_code == CH_LF) begin
                  c_x = '0;
                  r_x = r_x + 1'b1;
                end else if (in_item.char_code == CH_CR) begin
                  c_x = '0;
                end else if (in_item.char_code == CH_TAB) begin
                  c_x = (c_x + TAB_STEP) & TAB_MASK;
                end else begin
                  ram_req.we    = 1'b1;
                  ram_req.waddr = cell_addr(cur_row_r, cur_col_r);
                  ram_req.wdata = make_cell(in_item.char_code, in_item.color);
                  c_x           = c_x + 1'b1;
                end
                if (c_x >= COLS_X) begin
                  c_x = '0;
                  r_x = r_x + 1'b1;
                end
                cur_col_nxt = c_x[COL_W-1:0];
                if (r_x >= SCROLL_H_X) begin
                  // cursor parks on the last scroll row, then the copy runs
                  cur_row_nxt = SCROLL_TOP;
                  cnt_nxt     = '0;
                  state_nxt   = ST_SCROLL;
                end else begin
                  cur_row_nxt = r_x[ROW_W-1:0];
                  done        = 1'b1;
                end
              end
            end

            OP_WRITE: begin
              if ({2'b00, in_item.row} < ROWS_X && {1'b0, in_item.col} < COLS_X) begin
                ram_req.we    = 1'b1;
                ram_req.waddr = cell_addr(in_item.row, in_item.col);
                ram_req.wdata = make_cell(in_item.char_code, in_item.color);
              end
              done = 1'b1;
            end

            OP_CURSOR: begin
              cur_row_nxt = ({2'b00, in_item.row} < ROWS_X) ? in_item.row : ROW_LAST;
              cur_col_nxt = ({1'b0, in_item.col} < COLS_X) ? in_item.col : COL_LAST;
              done        = 1'b1;
            end

            OP_CLEAR: begin
              cur_row_nxt = '0;
              cur_col_nxt = '0;
              cnt_nxt     = '0;
              state_nxt   = ST_CLEAR;
            end

            OP_READ: begin
              if ({2'b00, in_item.row} < ROWS_X && {1'b0, in_item.col} < COLS_X) begin
                ram_req.re    = 1'b1;
                ram_req.raddr = cell_addr(in_item.row, in_item.col);
                state_nxt     = ST_READ;
              end else begin
                done = 1'b1;
              end
            end

            default: begin
              done = 1'b1;
            end
          endcase
        end
      end

      ST_READ: begin
        res.cell_char  = ram_rdata[CHAR_W-1:0];
        res.cell_color = ram_rdata[CELL_W-1:CHAR_W];
        done           = 1'b1;
        state_nxt      = ST_IDLE;
      end

      ST_SCROLL: begin
        // read one row below, write it back in the following cycle
        if (pend_r) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = waddr_r;
          ram_req.wdata = ram_rdata;
        end
        if (cnt_r == A_MOVED) begin
          state_nxt = ST_BLANK;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = cnt_r + A_COLS;
          pend_nxt      = 1'b1;
          waddr_nxt     = cnt_r;
          cnt_nxt       = cnt_r + 1'b1;
        end
      end

      ST_BLANK: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cnt_r;
        ram_req.wdata = make_cell(CH_SPACE, color_r);
        if (cnt_r == A_LAST_SCROLL) begin
          res.scrolled = 1'b1;
          done         = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    res.caret_row = cur_row_nxt;
    res.caret_col = cur_col_nxt;
  end

endmodule

`default_nettype wire

### hdl/text_console_cursor_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// text console cursor engine: a grid of character/attribute cells plus a cursor
// input channel: an item is taken on a clock edge with start high and busy low;
//   busy stays high while the item is being worked on
// result channel: out_valid is high for exactly one cycle per item, with out_item
//   carrying the cursor after the item and, for a cell read, the cell contents;
//   the receiver cannot hold results off, so nothing downstream ever stalls us
// the cells live in one simple dual-port ram (one write, one registered read)
// how each item is worked before its result is registered onto the output:
//   put char without scroll, backspace, write cell, set cursor, unused codes:
//     at accept; read cell: one registered ram read
//   put char that scrolls: one cell copied per cycle through the ram read port,
//     then the bottom scroll row blanked
//   clear: one cell a cycle through the ram write port
// items are handled one at a time; the next may start in the cycle its result
//   shows on the output register
// reset: a clearing pass writes every cell blank with attribute zero, with busy
//   high throughout; the cursor goes to (0,0)

module text_console_cursor_engine
  import tcc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire tcc_in_t in_item,
  output logic         out_valid,
  output tcc_out_t     out_item
);

  tcc_ram_req_t      ram_req;
  logic [CELL_W-1:0] ram_rdata;
  logic              done;
  tcc_res_t          res;

  logic     out_valid_r;
  tcc_out_t out_item_r, out_item_nxt;

  // cell store
  tcc_cell_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // operation sequencer and cursor
  tcc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .done      (done),
    .res       (res)
  );

  // result item, including the linear cursor location for the display side
  always_comb begin
    out_item_nxt.caret_row       = res.caret_row;
    out_item_nxt.caret_col       = res.caret_col;
    out_item_nxt.cursor_position = cursor_pos(res.caret_row, res.caret_col);
    out_item_nxt.cell_char       = res.cell_char;
    out_item_nxt.cell_color      = res.cell_color;
    out_item_nxt.scrolled        = res.scrolled;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= done;
    end
  end

  // payload only loads with a finished item
  always_ff @(posedge clk) begin
    if (done) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire
